/* src/hsvrgb_pkg.sv */
// Shared types and constants for the HSV to RGB pixel converter.
// Used by the front end, the back end and the top level; depends on nothing.
package hsvrgb_pkg;

    localparam int COMPONENT_BITS_DEFAULT = 8;
    localparam int QUEUE_DEPTH_DEFAULT    = 2;

    localparam int HUE_BITS    = 11;
    localparam int WEIGHT_BITS = 9;

    localparam logic [HUE_BITS-1:0]    HUE_TURN    = 11'd1536;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_FULL = 9'd256;

    // Sixty-degree sectors of the hue circle, named by the two colours they span.
    typedef enum logic [2:0] {
        SEC_RED_YELLOW   = 3'd0,
        SEC_YELLOW_GREEN = 3'd1,
        SEC_GREEN_CYAN   = 3'd2,
        SEC_CYAN_BLUE    = 3'd3,
        SEC_BLUE_MAGENTA = 3'd4,
        SEC_MAGENTA_RED  = 3'd5
    } sector_t;

    typedef struct packed {
        logic                   grey;
        sector_t                sector;
        logic [WEIGHT_BITS-1:0] weight;
    } hue_class_t;

endpackage

/* src/hsvrgb_front.sv */
// Front end: accepts pixels, classifies the hue and forms value times saturation.
// Depends on hsvrgb_pkg.
module hsvrgb_front #(
    parameter int COMPONENT_BITS = hsvrgb_pkg::COMPONENT_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          hsv_valid,
    output logic                          hsv_ready,
    input  logic [hsvrgb_pkg::HUE_BITS-1:0] hue,
    input  logic [COMPONENT_BITS-1:0]     saturation,
    input  logic [COMPONENT_BITS-1:0]     brightness,
    output logic                          item_valid,
    input  logic                          item_ready,
    output logic [2*COMPONENT_BITS-1:0]   product,
    output logic [COMPONENT_BITS-1:0]     val,
    output hsvrgb_pkg::hue_class_t        cls
);
    import hsvrgb_pkg::*;

    localparam int N = COMPONENT_BITS;

    logic               valid_reg;
    logic [2*N-1:0]     product_reg;
    logic [N-1:0]       val_reg;
    hue_class_t         cls_reg;
    logic               load;

    // A full turn folds back onto hue zero; anything past it is grey.
    function automatic hue_class_t classify_hue(input logic [HUE_BITS-1:0] h);
        logic [HUE_BITS-1:0]    hw;
        logic [WEIGHT_BITS-1:0] pos;
        logic [WEIGHT_BITS-1:0] span;
        hue_class_t             c;
        hw = (h == HUE_TURN) ? '0 : h;
        pos = hw[WEIGHT_BITS-1:0];
        span = pos[WEIGHT_BITS-1] ? (pos - WEIGHT_FULL) : (WEIGHT_FULL - pos);
        c.grey = (h > HUE_TURN);
        c.sector = sector_t'(hw[HUE_BITS-1:WEIGHT_BITS-1]);
        c.weight = WEIGHT_FULL - span;
        return c;
    endfunction

    assign hsv_ready = !valid_reg || item_ready;
    assign load      = hsv_valid && hsv_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (hsv_ready)
        begin
            valid_reg <= hsv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            product_reg <= brightness * saturation;
            val_reg     <= brightness;
            cls_reg     <= classify_hue(hue);
        end
    end

    assign item_valid = valid_reg;
    assign product    = product_reg;
    assign val        = val_reg;
    assign cls        = cls_reg;

endmodule

/* src/hsvrgb_queue.sv */
// Short register queue that decouples the front end from the back end.
// Generic in width and depth; depends on nothing.
module hsvrgb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count exceeds its depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on a lone push");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

/* src/hsvrgb_back.sv */
// Back end: chroma by rounded division by full scale, the intermediate channel,
// then channel ordering and offset. Three pipeline stages; depends on hsvrgb_pkg.
module hsvrgb_back #(
    parameter int COMPONENT_BITS = hsvrgb_pkg::COMPONENT_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  logic [2*COMPONENT_BITS-1:0] product,
    input  logic [COMPONENT_BITS-1:0]   val,
    input  hsvrgb_pkg::hue_class_t      cls,
    output logic                        rgb_valid,
    input  logic                        rgb_ready,
    output logic [COMPONENT_BITS-1:0]   red,
    output logic [COMPONENT_BITS-1:0]   green,
    output logic [COMPONENT_BITS-1:0]   blue
);
    import hsvrgb_pkg::*;

    localparam int N = COMPONENT_BITS;
    localparam logic [N-1:0]   CMAX    = '1;
    localparam logic [2*N-1:0] HALF    = (2*N)'(CMAX >> 1);
    localparam logic [N:0]     CMAX_X1 = {1'b0, CMAX};
    localparam logic [N:0]     CMAX_X2 = {CMAX, 1'b0};
    localparam logic [N+WEIGHT_BITS-1:0] ROUND_X = (N+WEIGHT_BITS)'(128);

    // Stage 1: chroma and offset.
    logic           v1_reg;
    logic [N-1:0]   chroma1_reg, m1_reg;
    hue_class_t     cls1_reg;
    // Stage 2: intermediate channel.
    logic           v2_reg;
    logic [N-1:0]   chroma2_reg, x2_reg, m2_reg;
    hue_class_t     cls2_reg;
    // Stage 3: output register.
    logic           v3_reg;
    logic [N-1:0]   red_reg, green_reg, blue_reg;

    logic           ready1, ready2, ready3;
    logic [2*N-1:0] rounded;
    logic [N:0]     digit_sum;
    logic [1:0]     corr;
    logic [N-1:0]   chroma_next;
    logic [N+WEIGHT_BITS-1:0] x_prod;
    logic [N-1:0]   r_sel, g_sel, b_sel;

    assign ready3     = !v3_reg || rgb_ready;
    assign ready2     = !v2_reg || ready3;
    assign ready1     = !v1_reg || ready2;
    assign item_ready = ready1;

    // Division by 2^N-1: with y = a*2^N + b, y/(2^N-1) = a + (a+b)/(2^N-1),
    // and a+b stays below twice the divisor plus one, so at most two is added.
    always_comb
    begin
        rounded   = product + HALF;
        digit_sum = {1'b0, rounded[2*N-1:N]} + {1'b0, rounded[N-1:0]};
        if (digit_sum >= CMAX_X2)
        begin
            corr = 2'd2;
        end
        else if (digit_sum >= CMAX_X1)
        begin
            corr = 2'd1;
        end
        else
        begin
            corr = 2'd0;
        end
        chroma_next = rounded[2*N-1:N] + N'(corr);
    end

    assign x_prod = ({{WEIGHT_BITS{1'b0}}, chroma1_reg} * {{N{1'b0}}, cls1_reg.weight})
                  + ROUND_X;

    always_comb
    begin
        r_sel = '0;
        g_sel = '0;
        b_sel = '0;
        case (cls2_reg.sector)
            SEC_RED_YELLOW:
            begin
                r_sel = chroma2_reg;
                g_sel = x2_reg;
            end
            SEC_YELLOW_GREEN:
            begin
                r_sel = x2_reg;
                g_sel = chroma2_reg;
            end
            SEC_GREEN_CYAN:
            begin
                g_sel = chroma2_reg;
                b_sel = x2_reg;
            end
            SEC_CYAN_BLUE:
            begin
                g_sel = x2_reg;
                b_sel = chroma2_reg;
            end
            SEC_BLUE_MAGENTA:
            begin
                r_sel = x2_reg;
                b_sel = chroma2_reg;
            end
            default:
            begin
                r_sel = chroma2_reg;
                b_sel = x2_reg;
            end
        endcase
        if (cls2_reg.grey)
        begin
            r_sel = '0;
            g_sel = '0;
            b_sel = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= item_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && item_valid)
        begin
            chroma1_reg <= chroma_next;
            m1_reg      <= val - chroma_next;
            cls1_reg    <= cls;
        end
        if (ready2 && v1_reg)
        begin
            chroma2_reg <= chroma1_reg;
            x2_reg      <= x_prod[N+7:8];
            m2_reg      <= m1_reg;
            cls2_reg    <= cls1_reg;
        end
        if (ready3 && v2_reg)
        begin
            red_reg   <= r_sel + m2_reg;
            green_reg <= g_sel + m2_reg;
            blue_reg  <= b_sel + m2_reg;
        end
    end

    assign rgb_valid = v3_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> v1_reg)
        else $error("back end refused a transaction with stage one empty");

    a_x_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (x2_reg <= chroma2_reg))
        else $error("intermediate channel exceeds chroma");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (({1'b0, chroma2_reg} + {1'b0, m2_reg}) <= CMAX_X1))
        else $error("chroma plus offset exceeds full scale");

endmodule

/* src/hsv_to_rgb_core.sv */
// Top level of the HSV to RGB pixel converter: front end, queue and back end.
// Depends on hsvrgb_pkg, hsvrgb_front, hsvrgb_queue and hsvrgb_back.
//
//   Channel   Handshake              Payload
//   --------  ---------------------  ------------------------------
//   hsv       hsv_valid/hsv_ready    hue, saturation, brightness
//   rgb       rgb_valid/rgb_ready    red, green, blue
//
// One pixel per clock is sustained while rgb_ready stays high; after the front
// end accepts a pixel, its result passes the queue write and the three back end
// stages (chroma, intermediate channel, output) before it is first shown.
// Reset clears all valid flags and the queue count; no pixel is in flight.
// A stall at the output fills the back end, then the queue, then the front.
module hsv_to_rgb_core #(
    parameter int COMPONENT_BITS = hsvrgb_pkg::COMPONENT_BITS_DEFAULT,
    parameter int QUEUE_DEPTH    = hsvrgb_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            hsv_valid,
    output logic                            hsv_ready,
    input  logic [hsvrgb_pkg::HUE_BITS-1:0] hue,
    input  logic [COMPONENT_BITS-1:0]       saturation,
    input  logic [COMPONENT_BITS-1:0]       brightness,
    output logic                            rgb_valid,
    input  logic                            rgb_ready,
    output logic [COMPONENT_BITS-1:0]       red,
    output logic [COMPONENT_BITS-1:0]       green,
    output logic [COMPONENT_BITS-1:0]       blue
);
    import hsvrgb_pkg::*;

    localparam int N      = COMPONENT_BITS;
    localparam int Q_BITS = 3 * N + $bits(hue_class_t);

    logic               f_valid, f_ready;
    logic [2*N-1:0]     f_product;
    logic [N-1:0]       f_val;
    hue_class_t         f_cls;
    logic               b_valid, b_ready;
    logic [Q_BITS-1:0]  q_in, q_out;
    logic [2*N-1:0]     b_product;
    logic [N-1:0]       b_val;
    hue_class_t         b_cls;

    hsvrgb_front #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .hsv_valid  (hsv_valid),
        .hsv_ready  (hsv_ready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .product    (f_product),
        .val        (f_val),
        .cls        (f_cls)
    );

    assign q_in = {f_product, f_val, f_cls};

    hsvrgb_queue #(
        .WIDTH (Q_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (q_in),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (q_out)
    );

    assign {b_product, b_val, b_cls} = q_out;

    hsvrgb_back #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (b_valid),
        .item_ready (b_ready),
        .product    (b_product),
        .val        (b_val),
        .cls        (b_cls),
        .rgb_valid  (rgb_valid),
        .rgb_ready  (rgb_ready),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

endmodule
